FILE: src/csfs_pkg.sv
// Package for the command source failsafe selector.
// Holds the input and result word types, the source codes and the check result type.
// No dependencies.
package csfs_pkg;

  // Source codes carried in chosen_source.
  localparam logic [1:0] SRC_PRIMARY   = 2'd0;
  localparam logic [1:0] SRC_AUX       = 2'd1;
  localparam logic [1:0] SRC_EMERGENCY = 2'd2;

  // Latency limit after reset, in milliseconds.
  localparam logic [15:0] LATENCY_RESET_MS = 16'd40;

  // One input word, one per control tick.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        primary_speed_received;
    logic        primary_torque_received;
    logic [31:0] primary_speed_stamp;
    logic [31:0] primary_torque_stamp;
    logic        aux_speed_received;
    logic        aux_torque_received;
    logic [31:0] aux_speed_stamp;
    logic [31:0] aux_torque_stamp;
    logic        reinit_button;
  } csfs_in_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  chosen_source;
    logic        primary_failed;
    logic        aux_failed;
    logic        run_enabled;
    logic [31:0] worst_speed_age;
    logic [31:0] worst_torque_age;
  } csfs_out_t;

  // Timing check result of one source.
  typedef struct packed {
    logic        fail;
    logic [31:0] speed_age;
    logic [31:0] torque_age;
  } csfs_check_t;

endpackage

FILE: src/csfs_if.sv
// Handshake channel interfaces for the command source failsafe selector.
// Depends on csfs_pkg for the word types.
interface csfs_in_if;
  logic                valid;
  logic                ready;
  csfs_pkg::csfs_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csfs_out_if;
  logic                valid;
  logic                ready;
  csfs_pkg::csfs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/csfs_src_check.sv
// Timing check of one command source: received flags, message ages and skew.
// Depends on csfs_pkg for the check result type.
module csfs_src_check (
  input  logic [31:0]          now_ms,
  input  logic                 speed_received,
  input  logic                 torque_received,
  input  logic [31:0]          speed_stamp,
  input  logic [31:0]          torque_stamp,
  input  logic [15:0]          limit_ms,
  output csfs_pkg::csfs_check_t check
);
  import csfs_pkg::*;

  // True when the magnitude of a wrapped signed difference exceeds the limit.
  // The most negative difference negates to itself, which reads as 2^31 and fails.
  function automatic logic mag_exceeds(input logic [31:0] diff, input logic [15:0] lim);
    logic [31:0] mag;
    mag = diff[31] ? (32'd0 - diff) : diff;
    return mag > {16'd0, lim};
  endfunction

  logic [31:0] speed_age;
  logic [31:0] torque_age;
  logic [31:0] skew;
  logic        missing;
  logic        speed_old;
  logic        torque_old;
  logic        skewed;

  // Wrapped differences.
  assign speed_age  = now_ms - speed_stamp;
  assign torque_age = now_ms - torque_stamp;
  assign skew       = speed_stamp - torque_stamp;

  // Individual failure reasons; skew is held to half the limit.
  assign missing    = !speed_received || !torque_received;
  assign speed_old  = mag_exceeds(speed_age, limit_ms);
  assign torque_old = mag_exceeds(torque_age, limit_ms);
  assign skewed     = mag_exceeds(skew, {1'b0, limit_ms[15:1]});

  assign check.fail       = missing || speed_old || torque_old || skewed;
  assign check.speed_age  = speed_age;
  assign check.torque_age = torque_age;

endmodule

FILE: src/command_source_failsafe_selector_core.sv
// Command source failsafe selector, top level.
// Depends on csfs_pkg, the channel interfaces in csfs_if.sv and csfs_src_check.
//
// The block takes one word per clock cycle while the result does not stall, and
// returns one result word for each: the word is held in an input register,
// checked and selected in one pass of compares and subtractions, and stored in the
// result register. The run flag and worst ages are updated as each word moves into
// the result register, so the next word already sees them. A stalled result only
// holds the input register; one more word is taken while the result waits.
// The latency limit register is always ready and should be written only while idle.
module command_source_failsafe_selector_core (
  input  logic       clk,
  input  logic       rst_n,
  csfs_in_if.sink    in_ch,
  csfs_out_if.source out_ch,
  csfs_cfg_if.sink   cfg_ch
);
  import csfs_pkg::*;

  // Input register.
  logic        in_valid_r;
  csfs_in_t    in_word_r;
  // Result register.
  logic        out_valid_r;
  csfs_out_t   out_word_r;
  csfs_out_t   out_word_nxt;
  // Configuration and running state.
  logic [15:0] limit_r;
  logic        run_r;
  logic        run_nxt;
  logic [31:0] worst_speed_r;
  logic [31:0] worst_speed_nxt;
  logic [31:0] worst_torque_r;
  logic [31:0] worst_torque_nxt;

  logic        advance;
  csfs_check_t prim_chk;
  csfs_check_t aux_chk;
  logic [31:0] worst_speed_mid;
  logic [31:0] worst_torque_mid;
  logic        run_set;
  logic [1:0]  chosen;

  // Handshake: the input word moves on when the result register is free or draining.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // Timing checks of both sources.
  csfs_src_check u_prim_chk (
    .now_ms          (in_word_r.now_ms),
    .speed_received  (in_word_r.primary_speed_received),
    .torque_received (in_word_r.primary_torque_received),
    .speed_stamp     (in_word_r.primary_speed_stamp),
    .torque_stamp    (in_word_r.primary_torque_stamp),
    .limit_ms        (limit_r),
    .check           (prim_chk)
  );

  csfs_src_check u_aux_chk (
    .now_ms          (in_word_r.now_ms),
    .speed_received  (in_word_r.aux_speed_received),
    .torque_received (in_word_r.aux_torque_received),
    .speed_stamp     (in_word_r.aux_speed_stamp),
    .torque_stamp    (in_word_r.aux_torque_stamp),
    .limit_ms        (limit_r),
    .check           (aux_chk)
  );

  // Worst ages: primary then auxiliary; torque only counts when speed did not rise.
  always_comb begin
    worst_speed_mid  = worst_speed_r;
    worst_torque_mid = worst_torque_r;
    if (prim_chk.speed_age > worst_speed_r) begin
      worst_speed_mid = prim_chk.speed_age;
    end else if (prim_chk.torque_age > worst_torque_r) begin
      worst_torque_mid = prim_chk.torque_age;
    end
    worst_speed_nxt  = worst_speed_mid;
    worst_torque_nxt = worst_torque_mid;
    if (aux_chk.speed_age > worst_speed_mid) begin
      worst_speed_nxt = aux_chk.speed_age;
    end else if (aux_chk.torque_age > worst_torque_mid) begin
      worst_torque_nxt = aux_chk.torque_age;
    end
  end

  // Source selection; falling back to emergency drops the run flag.
  assign run_set = run_r || in_word_r.reinit_button;

  always_comb begin
    if (run_set && !prim_chk.fail) begin
      chosen  = SRC_PRIMARY;
      run_nxt = 1'b1;
    end else if (run_set && !aux_chk.fail) begin
      chosen  = SRC_AUX;
      run_nxt = 1'b1;
    end else begin
      chosen  = SRC_EMERGENCY;
      run_nxt = 1'b0;
    end
  end

  always_comb begin
    out_word_nxt.chosen_source    = chosen;
    out_word_nxt.primary_failed   = prim_chk.fail;
    out_word_nxt.aux_failed       = aux_chk.fail;
    out_word_nxt.run_enabled      = run_nxt;
    out_word_nxt.worst_speed_age  = worst_speed_nxt;
    out_word_nxt.worst_torque_age = worst_torque_nxt;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      limit_r        <= LATENCY_RESET_MS;
      run_r          <= 1'b0;
      worst_speed_r  <= 32'd0;
      worst_torque_r <= 32'd0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        run_r          <= run_nxt;
        worst_speed_r  <= worst_speed_nxt;
        worst_torque_r <= worst_torque_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r <= in_ch.data;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

FILE: src/csfs_checker.sv
// Port-level checks of the command source failsafe selector, and their binding.
// Depends on csfs_pkg and on the top level command_source_failsafe_selector_core.
module csfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input csfs_pkg::csfs_out_t out_data
);
  import csfs_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // The primary source is only chosen when it passed and the run flag stays set.
  a_primary_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_source == SRC_PRIMARY
      |-> !out_data.primary_failed && out_data.run_enabled)
    else $error("primary chosen although failed or disabled");

  // The auxiliary source is only chosen when the primary failed and it passed.
  a_aux_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_source == SRC_AUX
      |-> out_data.primary_failed && !out_data.aux_failed && out_data.run_enabled)
    else $error("auxiliary chosen out of order");

  // Emergency always leaves the external sources disabled.
  a_emergency_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_source == SRC_EMERGENCY |-> !out_data.run_enabled)
    else $error("run flag left set under emergency");

endmodule

bind command_source_failsafe_selector_core csfs_checker u_csfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
